FILE: rtl/clafsm_pkg.sv
// Package for the chamber light activity controller: item and result structs,
// strip state and action codes, register indexes and the colour and fade helpers.
// Depends on nothing; used by chamber_light_activity_fsm.
package clafsm_pkg;

    // Action codes carried in the item's action field.
    localparam logic [2:0] ACT_UPDATE      = 3'd0;
    localparam logic [2:0] ACT_ACTIVITY    = 3'd1;
    localparam logic [2:0] ACT_IDLE        = 3'd2;
    localparam logic [2:0] ACT_PRINT_DONE  = 3'd3;
    localparam logic [2:0] ACT_DOOR        = 3'd4;
    localparam logic [2:0] ACT_CUSTOM      = 3'd5;
    localparam logic [2:0] ACT_PRINT_LIGHT = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_DIM_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_OFF_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_DOOR_ACTIVE = 3'd2;
    localparam logic [2:0] REG_HOLD_PRINT  = 3'd3;
    localparam logic [2:0] REG_LEVEL_MASK  = 3'd4;
    localparam logic [2:0] REG_LEVELS      = 3'd5;

    // Strip state codes as they appear in the result.
    localparam logic [2:0] CODE_UNKNOWN  = 3'd0;
    localparam logic [2:0] CODE_OFF      = 3'd1;
    localparam logic [2:0] CODE_DIMMED   = 3'd2;
    localparam logic [2:0] CODE_IDLE     = 3'd3;
    localparam logic [2:0] CODE_ACTIVE   = 3'd4;
    localparam logic [2:0] CODE_PRINTING = 3'd5;
    localparam logic [2:0] CODE_CUSTOM   = 3'd6;

    // Timeouts are kept in milliseconds; 65535 s * 1000 fits in 26 bits.
    localparam int unsigned MS_W      = 26;
    localparam int unsigned MS_PER_S  = 1000;
    localparam logic [31:0] FADE_SLOW = 32'd5000;
    localparam logic [31:0] FADE_FAST = 32'd500;

    localparam logic [15:0] DIM_TIMEOUT_RST = 16'd120;
    localparam logic [31:0] LEVELS_RST      = 32'hFFFF_FF00;

    typedef enum logic [6:0] {
        ST_UNKNOWN  = 7'b000_0001,
        ST_OFF      = 7'b000_0010,
        ST_DIMMED   = 7'b000_0100,
        ST_IDLE     = 7'b000_1000,
        ST_ACTIVE   = 7'b001_0000,
        ST_PRINTING = 7'b010_0000,
        ST_CUSTOM   = 7'b100_0000
    } strip_state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic        print_running;
        logic        guided_dialog;
        logic        finishing;
        logic        finishing_wait_idle;
        logic        door_open;
        logic [7:0]  light_value;
        logic [31:0] custom_rgbw;
        logic [31:0] custom_duration_ms;
        logic [31:0] custom_fade_ms;
    } item_t;

    typedef struct packed {
        logic [2:0]  strip_state;
        logic        state_changed;
        logic [31:0] target_rgbw;
        logic [31:0] fade_ms;
        logic        hold_active;
        logic        hold_dismissed;
    } result_t;

    function automatic logic [2:0] state_code(input strip_state_t s);
        logic [2:0] code;
        unique case (s)
            ST_UNKNOWN:  code = CODE_UNKNOWN;
            ST_OFF:      code = CODE_OFF;
            ST_DIMMED:   code = CODE_DIMMED;
            ST_IDLE:     code = CODE_IDLE;
            ST_ACTIVE:   code = CODE_ACTIVE;
            ST_PRINTING: code = CODE_PRINTING;
            ST_CUSTOM:   code = CODE_CUSTOM;
            default:     code = CODE_UNKNOWN;
        endcase
        return code;
    endfunction

    // Target colour for a state. Levels drive the white LED, so they land in
    // the W byte; an override on the printing level ignores its mask bit.
    function automatic logic [31:0] colour_for(
        input strip_state_t s,
        input logic [3:0]   mask,
        input logic [31:0]  levels,
        input logic         ovr_valid,
        input logic [7:0]   ovr_level,
        input logic [31:0]  custom
    );
        logic        enabled;
        logic [31:0] colour;
        unique case (s) inside
            ST_PRINTING:          enabled = mask[3] || ovr_valid;
            ST_ACTIVE, ST_CUSTOM: enabled = mask[2];
            ST_DIMMED, ST_IDLE:   enabled = mask[1];
            default:              enabled = mask[0];
        endcase
        unique case (s) inside
            ST_OFF:             colour = {24'd0, levels[7:0]};
            ST_DIMMED:          colour = {24'd0, levels[15:8]};
            ST_ACTIVE, ST_IDLE: colour = {24'd0, levels[23:16]};
            ST_PRINTING:        colour = {24'd0, ovr_valid ? ovr_level : levels[31:24]};
            ST_CUSTOM:          colour = custom;
            default:            colour = 32'd0;
        endcase
        return enabled ? colour : 32'd0;
    endfunction

    function automatic logic [31:0] fade_for(input strip_state_t s,
                                             input logic [31:0] custom_fade);
        logic [31:0] fade;
        unique case (s) inside
            ST_DIMMED, ST_IDLE: fade = FADE_SLOW;
            ST_CUSTOM:          fade = custom_fade;
            default:            fade = FADE_FAST;
        endcase
        return fade;
    endfunction

endpackage

FILE: rtl/chamber_light_activity_fsm.sv
// Chamber light activity controller: input register, one pass of state logic,
// result register. Depends on clafsm_pkg for types, codes and colour helpers.
//
//  channel   direction  handshake                     payload
//  item      in         item_valid / item_stall       clafsm_pkg::item_t
//  result    out        result_valid / result_stall   clafsm_pkg::result_t
//  config    in         cfg_write                     cfg_index[2:0], cfg_data[31:0]
//
// One item is taken every cycle while item_stall is low; its result passes
// from the input register through the state update into the result register,
// and it leaves the result register while result_stall is low.
// The state update is a single pass: one wrap-around subtract for elapsed
// time, one subtract and two compares against the millisecond timeouts.
// Reset is asynchronous and needs no clearing pass afterwards.
// A stalled result holds the pipeline; the input register fills once more.
module chamber_light_activity_fsm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  clafsm_pkg::item_t      item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output clafsm_pkg::result_t    result,
    input  logic                   cfg_write,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data
);

    // Pipeline registers.
    logic                  in_vld_reg, in_vld_next;
    clafsm_pkg::item_t     in_data_reg;
    logic                  out_vld_reg, out_vld_next;
    clafsm_pkg::result_t   out_data_reg, out_data_next;
    logic                  accept, advance;

    // Configuration.
    logic [clafsm_pkg::MS_W-1:0] dim_ms_reg, dim_ms_next;
    logic [clafsm_pkg::MS_W-1:0] off_ms_reg, off_ms_next;
    logic                  door_keeps_reg, door_keeps_next;
    logic                  hold_print_reg, hold_print_next;
    logic [3:0]            mask_reg, mask_next;
    logic [31:0]           levels_reg, levels_next;

    // Controller state.
    clafsm_pkg::strip_state_t cur_state_reg, cur_state_next;
    logic [31:0]           stamp_reg, stamp_next;
    logic                  host_idle_reg, host_idle_next;
    logic                  was_busy_reg, was_busy_next;
    logic                  hold_reg, hold_next;
    logic                  dismissed_reg, dismissed_next;
    logic                  door_seen_reg, door_seen_next;
    logic                  door_latched_reg, door_latched_next;
    logic                  custom_vld_reg, custom_vld_next;
    logic [31:0]           custom_colour_reg, custom_colour_next;
    logic [31:0]           custom_start_reg, custom_start_next;
    logic [31:0]           custom_len_reg, custom_len_next;
    logic [31:0]           custom_fade_reg, custom_fade_next;
    logic                  light_dis_reg, light_dis_next;
    logic                  ovr_vld_reg, ovr_vld_next;
    logic [7:0]            ovr_level_reg, ovr_level_next;

    // Update pass working signals.
    clafsm_pkg::strip_state_t goal;
    logic                  go;
    logic                  custom_live;
    logic                  pa, ga;
    logic [31:0]           elapsed;
    logic [31:0]           over_dim;
    logic [31:0]           dim_ms32, off_ms32;

    assign advance      = in_vld_reg && (!out_vld_reg || !result_stall);
    assign item_stall   = in_vld_reg && !advance;
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_vld_reg;
    assign result       = out_data_reg;

    assign in_vld_next  = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : ((out_vld_reg && !result_stall) ? 1'b0 : out_vld_reg);

    assign dim_ms32    = 32'(dim_ms_reg);
    assign off_ms32    = 32'(off_ms_reg);
    assign custom_live = custom_vld_reg && ((custom_len_reg == 32'd0) ||
                         ((in_data_reg.now_ms - custom_start_reg) < custom_len_reg));
    assign pa = in_data_reg.print_running && !host_idle_reg;
    assign ga = in_data_reg.guided_dialog && !host_idle_reg && !in_data_reg.finishing;

    always_comb
    begin
        dim_ms_next        = dim_ms_reg;
        off_ms_next        = off_ms_reg;
        door_keeps_next    = door_keeps_reg;
        hold_print_next    = hold_print_reg;
        mask_next          = mask_reg;
        levels_next        = levels_reg;
        cur_state_next     = cur_state_reg;
        stamp_next         = stamp_reg;
        host_idle_next     = host_idle_reg;
        was_busy_next      = was_busy_reg;
        hold_next          = hold_reg;
        dismissed_next     = dismissed_reg;
        door_seen_next     = door_seen_reg;
        door_latched_next  = door_latched_reg;
        custom_vld_next    = custom_vld_reg;
        custom_colour_next = custom_colour_reg;
        custom_start_next  = custom_start_reg;
        custom_len_next    = custom_len_reg;
        custom_fade_next   = custom_fade_reg;
        light_dis_next     = light_dis_reg;
        ovr_vld_next       = ovr_vld_reg;
        ovr_level_next     = ovr_level_reg;
        goal               = clafsm_pkg::ST_UNKNOWN;
        go                 = 1'b0;
        elapsed            = 32'd0;
        over_dim           = 32'd0;
        out_data_next      = '0;

        if (advance)
        begin
            case (in_data_reg.action)
                clafsm_pkg::ACT_UPDATE:
                begin
                    if (custom_live)
                    begin
                        goal = clafsm_pkg::ST_CUSTOM;
                        go   = 1'b1;
                    end
                    else if (pa)
                    begin
                        custom_vld_next = 1'b0;
                        was_busy_next   = 1'b1;
                        hold_next       = 1'b0;
                        dismissed_next  = 1'b0;
                        door_seen_next  = 1'b0;
                        goal = light_dis_reg ? clafsm_pkg::ST_OFF : clafsm_pkg::ST_PRINTING;
                        go   = 1'b1;
                    end
                    else
                    begin
                        custom_vld_next = 1'b0;
                        light_dis_next  = 1'b0;
                        ovr_vld_next    = 1'b0;
                        // The end of a print settles the activity stamp first.
                        if (was_busy_reg && in_data_reg.finishing_wait_idle)
                        begin
                            stamp_next = in_data_reg.now_ms;
                        end
                        else if (was_busy_reg && in_data_reg.finishing && hold_print_reg)
                        begin
                            was_busy_next  = 1'b0;
                            hold_next      = 1'b1;
                            dismissed_next = 1'b0;
                            door_seen_next = door_latched_reg;
                            stamp_next     = in_data_reg.now_ms;
                        end
                        else if (was_busy_reg && in_data_reg.finishing)
                        begin
                            was_busy_next = 1'b0;
                            stamp_next    = 32'd0;
                        end
                        else if (was_busy_reg)
                        begin
                            was_busy_next = 1'b0;
                            stamp_next    = in_data_reg.now_ms;
                        end

                        go       = 1'b1;
                        elapsed  = in_data_reg.now_ms - stamp_next;
                        over_dim = elapsed - dim_ms32;
                        if (ga)
                        begin
                            stamp_next = in_data_reg.now_ms;
                            goal       = clafsm_pkg::ST_ACTIVE;
                        end
                        else if (door_latched_reg && door_keeps_reg)
                        begin
                            goal = clafsm_pkg::ST_ACTIVE;
                        end
                        else if (stamp_next == 32'd0)
                        begin
                            goal = clafsm_pkg::ST_OFF;
                        end
                        else if ((off_ms32 != 32'd0) && (elapsed >= dim_ms32) &&
                                 (over_dim >= off_ms32))
                        begin
                            stamp_next = 32'd0;
                            goal       = clafsm_pkg::ST_OFF;
                        end
                        else if (elapsed >= dim_ms32)
                        begin
                            goal = clafsm_pkg::ST_DIMMED;
                        end
                        else
                        begin
                            goal = clafsm_pkg::ST_ACTIVE;
                        end
                    end
                end
                clafsm_pkg::ACT_ACTIVITY:
                begin
                    host_idle_next = 1'b0;
                    stamp_next     = in_data_reg.now_ms;
                end
                clafsm_pkg::ACT_IDLE:
                begin
                    host_idle_next = 1'b1;
                    if (!door_latched_reg)
                    begin
                        hold_next      = 1'b0;
                        dismissed_next = 1'b1;
                        door_seen_next = 1'b0;
                        stamp_next     = 32'd0;
                        cur_state_next = clafsm_pkg::ST_UNKNOWN;
                    end
                end
                clafsm_pkg::ACT_PRINT_DONE:
                begin
                    host_idle_next = 1'b0;
                    was_busy_next  = 1'b0;
                    door_seen_next = door_latched_reg;
                    dismissed_next = 1'b0;
                    hold_next      = hold_print_reg;
                    if (hold_print_reg)
                    begin
                        stamp_next     = in_data_reg.now_ms;
                        cur_state_next = clafsm_pkg::ST_UNKNOWN;
                    end
                    else
                    begin
                        stamp_next = 32'd0;
                    end
                end
                clafsm_pkg::ACT_DOOR:
                begin
                    if (door_latched_reg != in_data_reg.door_open)
                    begin
                        door_latched_next = in_data_reg.door_open;
                        host_idle_next    = 1'b0;
                        stamp_next        = in_data_reg.now_ms;
                        // A close after an open seen during the hold dismisses it.
                        if (hold_reg && in_data_reg.door_open)
                        begin
                            door_seen_next = 1'b1;
                        end
                        else if (hold_reg && door_seen_reg)
                        begin
                            hold_next      = 1'b0;
                            dismissed_next = 1'b1;
                            door_seen_next = 1'b0;
                            cur_state_next = clafsm_pkg::ST_UNKNOWN;
                        end
                    end
                end
                clafsm_pkg::ACT_CUSTOM:
                begin
                    custom_vld_next    = 1'b1;
                    custom_colour_next = in_data_reg.custom_rgbw;
                    custom_start_next  = in_data_reg.now_ms;
                    custom_len_next    = in_data_reg.custom_duration_ms;
                    custom_fade_next   = in_data_reg.custom_fade_ms;
                    cur_state_next     = clafsm_pkg::ST_OFF;
                end
                clafsm_pkg::ACT_PRINT_LIGHT:
                begin
                    ovr_level_next = in_data_reg.light_value;
                    ovr_vld_next   = 1'b1;
                    light_dis_next = (in_data_reg.light_value == 8'd0);
                    host_idle_next = 1'b0;
                    cur_state_next = clafsm_pkg::ST_UNKNOWN;
                end
                default:
                begin
                end
            endcase

            if (go && (goal != cur_state_reg))
            begin
                cur_state_next              = goal;
                out_data_next.state_changed = 1'b1;
                out_data_next.fade_ms       = clafsm_pkg::fade_for(goal, custom_fade_reg);
                out_data_next.target_rgbw   = clafsm_pkg::colour_for(goal, mask_reg,
                                                  levels_reg, ovr_vld_next, ovr_level_reg,
                                                  custom_colour_reg);
            end
            out_data_next.strip_state    = clafsm_pkg::state_code(cur_state_next);
            out_data_next.hold_active    = hold_next &&
                                           (cur_state_next != clafsm_pkg::ST_OFF);
            out_data_next.hold_dismissed = dismissed_next;
        end

        // Configuration writes are for the user to make only while the block is idle; the block does not enforce it.
        if (cfg_write)
        begin
            unique case (cfg_index)
                clafsm_pkg::REG_DIM_TIMEOUT:
                    dim_ms_next = clafsm_pkg::MS_W'(cfg_data[15:0]) *
                                  clafsm_pkg::MS_W'(clafsm_pkg::MS_PER_S);
                clafsm_pkg::REG_OFF_TIMEOUT:
                    off_ms_next = clafsm_pkg::MS_W'(cfg_data[15:0]) *
                                  clafsm_pkg::MS_W'(clafsm_pkg::MS_PER_S);
                clafsm_pkg::REG_DOOR_ACTIVE:
                    door_keeps_next = cfg_data[0];
                clafsm_pkg::REG_HOLD_PRINT:
                begin
                    hold_print_next = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        hold_next      = 1'b0;
                        dismissed_next = 1'b0;
                        door_seen_next = 1'b0;
                    end
                end
                clafsm_pkg::REG_LEVEL_MASK:
                begin
                    mask_next      = cfg_data[3:0];
                    cur_state_next = clafsm_pkg::ST_UNKNOWN;
                end
                clafsm_pkg::REG_LEVELS:
                begin
                    levels_next    = cfg_data;
                    cur_state_next = clafsm_pkg::ST_UNKNOWN;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            dim_ms_reg       <= clafsm_pkg::MS_W'(clafsm_pkg::DIM_TIMEOUT_RST) *
                                clafsm_pkg::MS_W'(clafsm_pkg::MS_PER_S);
            off_ms_reg       <= '0;
            door_keeps_reg   <= 1'b1;
            hold_print_reg   <= 1'b0;
            mask_reg         <= 4'hF;
            levels_reg       <= clafsm_pkg::LEVELS_RST;
            cur_state_reg    <= clafsm_pkg::ST_UNKNOWN;
            stamp_reg        <= 32'd0;
            host_idle_reg    <= 1'b0;
            was_busy_reg     <= 1'b0;
            hold_reg         <= 1'b0;
            dismissed_reg    <= 1'b0;
            door_seen_reg    <= 1'b0;
            door_latched_reg <= 1'b0;
            custom_vld_reg   <= 1'b0;
            custom_colour_reg <= 32'd0;
            custom_start_reg <= 32'd0;
            custom_len_reg   <= 32'd0;
            custom_fade_reg  <= 32'd0;
            light_dis_reg    <= 1'b0;
            ovr_vld_reg      <= 1'b0;
            ovr_level_reg    <= 8'd0;
        end
        else
        begin
            in_vld_reg       <= in_vld_next;
            out_vld_reg      <= out_vld_next;
            dim_ms_reg       <= dim_ms_next;
            off_ms_reg       <= off_ms_next;
            door_keeps_reg   <= door_keeps_next;
            hold_print_reg   <= hold_print_next;
            mask_reg         <= mask_next;
            levels_reg       <= levels_next;
            cur_state_reg    <= cur_state_next;
            stamp_reg        <= stamp_next;
            host_idle_reg    <= host_idle_next;
            was_busy_reg     <= was_busy_next;
            hold_reg         <= hold_next;
            dismissed_reg    <= dismissed_next;
            door_seen_reg    <= door_seen_next;
            door_latched_reg <= door_latched_next;
            custom_vld_reg   <= custom_vld_next;
            custom_colour_reg <= custom_colour_next;
            custom_start_reg <= custom_start_next;
            custom_len_reg   <= custom_len_next;
            custom_fade_reg  <= custom_fade_next;
            light_dis_reg    <= light_dis_next;
            ovr_vld_reg      <= ovr_vld_next;
            ovr_level_reg    <= ovr_level_next;
        end
    end

    // Payload registers load on transfer and need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= item;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A result without a new target carries neither colour nor fade.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_data_reg.state_changed) |->
            (out_data_reg.target_rgbw == 32'd0 && out_data_reg.fade_ms == 32'd0))
        else $error("idle result carries a target");

    // The hold is never reported while the strip is off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_data_reg.hold_active) |->
            (out_data_reg.strip_state != clafsm_pkg::CODE_OFF))
        else $error("hold reported in off state");

    // A new target always leads into a known state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_data_reg.state_changed) |->
            (out_data_reg.strip_state != clafsm_pkg::CODE_UNKNOWN))
        else $error("target issued for unknown state");

    // An item in the input register moves on whenever the result side is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !(out_vld_reg && result_stall)) |=> out_vld_reg)
        else $error("item lost between stages");

endmodule
